@@ rtl/core/rvalu_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I register ALU package
// Shared types and constants for the register-register execute unit.
// ----------------------------------------------------------------------------
package rvalu_pkg;

    localparam int XLEN     = 32;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = 5;
    localparam int SHAMT_W  = 5;

    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_SLTU    = 3'd3;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_SLL  = 4'd2,
        OP_SLT  = 4'd3,
        OP_SLTU = 4'd4,
        OP_XOR  = 4'd5,
        OP_SRL  = 4'd6,
        OP_SRA  = 4'd7,
        OP_OR   = 4'd8,
        OP_AND  = 4'd9,
        OP_BAD  = 4'd10
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs1;
        logic [REG_AW-1:0] rs2;
        logic              wr;
    } t_uop;

endpackage

@@ rtl/core/rvalu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rvalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rvalu_front.sv @@
// ----------------------------------------------------------------------------
// RV32I register ALU front end
// Splits the instruction word and classifies the operation and write enable.
// ----------------------------------------------------------------------------
module rvalu_front (
    input  logic [31:0]       i_instruction,
    output rvalu_pkg::t_uop   o_uop
);

    logic [2:0] f3;
    logic [6:0] f7;
    rvalu_pkg::t_op op;

    assign f3 = i_instruction[14:12];
    assign f7 = i_instruction[31:25];

    always_comb begin
        op = rvalu_pkg::OP_BAD;
        unique case (f3)
            rvalu_pkg::F3_ADD_SUB: begin
                if (f7 == rvalu_pkg::F7_BASE) begin
                    op = rvalu_pkg::OP_ADD;
                end else if (f7 == rvalu_pkg::F7_ALT) begin
                    op = rvalu_pkg::OP_SUB;
                end
            end
            rvalu_pkg::F3_SLL:  op = rvalu_pkg::OP_SLL;
            rvalu_pkg::F3_SLT:  op = rvalu_pkg::OP_SLT;
            rvalu_pkg::F3_SLTU: op = rvalu_pkg::OP_SLTU;
            rvalu_pkg::F3_XOR:  op = rvalu_pkg::OP_XOR;
            rvalu_pkg::F3_SRL_SRA: begin
                if (f7 == rvalu_pkg::F7_BASE) begin
                    op = rvalu_pkg::OP_SRL;
                end else if (f7 == rvalu_pkg::F7_ALT) begin
                    op = rvalu_pkg::OP_SRA;
                end
            end
            rvalu_pkg::F3_OR:   op = rvalu_pkg::OP_OR;
            rvalu_pkg::F3_AND:  op = rvalu_pkg::OP_AND;
            default:            op = rvalu_pkg::OP_BAD;
        endcase
    end

    assign o_uop.op  = op;
    assign o_uop.rd  = i_instruction[11:7];
    assign o_uop.rs1 = i_instruction[19:15];
    assign o_uop.rs2 = i_instruction[24:20];
    assign o_uop.wr  = (op != rvalu_pkg::OP_BAD) && (i_instruction[11:7] != '0);

endmodule

@@ rtl/core/rvalu_queue.sv @@
// ----------------------------------------------------------------------------
// RV32I register ALU decoded queue
// Small FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module rvalu_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rvalu_pkg::t_uop i_uop,
    input  logic            i_pop,
    output rvalu_pkg::t_uop o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rvalu_pkg::t_uop r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

@@ rtl/core/rvalu_back.sv @@
// ----------------------------------------------------------------------------
// RV32I register ALU back end
// Register file read, ALU, write-back with bypass, and result register.
// ----------------------------------------------------------------------------
module rvalu_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  rvalu_pkg::t_uop           i_q_head,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [3:0]                o_operation,
    output logic [4:0]                o_dest_index,
    output logic signed [31:0]        o_write_value,
    output logic                      o_did_write
);

    localparam int XLEN = rvalu_pkg::XLEN;

    rvalu_pkg::t_uop r_ex;
    logic            r_ex_vld;
    logic            r_a_vld, r_b_vld;
    logic            r_a_fwd, r_b_fwd;
    logic [XLEN-1:0] r_fwd_val;
    logic [rvalu_pkg::NUM_REGS-1:0] r_reg_vld;

    logic            r_out_vld;
    logic [3:0]      r_out_op;
    logic [4:0]      r_out_rd;
    logic [XLEN-1:0] r_out_val;
    logic            r_out_wr;

    logic [XLEN-1:0] ram_a, ram_b;
    logic [XLEN-1:0] opa, opb;
    logic [XLEN-1:0] ex_val;
    logic [rvalu_pkg::SHAMT_W-1:0] sh;
    logic            out_rdy, ex_adv, ex_we, pop;

    assign out_rdy = !r_out_vld || !i_out_stall;
    assign ex_adv  = r_ex_vld && out_rdy;
    assign ex_we   = ex_adv && r_ex.wr;
    assign pop     = !i_q_empty && (!r_ex_vld || ex_adv);

    rvalu_ram #(.WIDTH(XLEN), .DEPTH(rvalu_pkg::NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (r_ex.rd),
        .i_wdata (ex_val),
        .i_re    (pop),
        .i_raddr (i_q_head.rs1),
        .o_rdata (ram_a)
    );

    rvalu_ram #(.WIDTH(XLEN), .DEPTH(rvalu_pkg::NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (r_ex.rd),
        .i_wdata (ex_val),
        .i_re    (pop),
        .i_raddr (i_q_head.rs2),
        .o_rdata (ram_b)
    );

    // bypass the write that lands on the same edge as the read
    assign opa = r_a_fwd ? r_fwd_val : (r_a_vld ? ram_a : '0);
    assign opb = r_b_fwd ? r_fwd_val : (r_b_vld ? ram_b : '0);
    assign sh  = opb[rvalu_pkg::SHAMT_W-1:0];

    always_comb begin
        unique case (r_ex.op)
            rvalu_pkg::OP_ADD:  ex_val = opa + opb;
            rvalu_pkg::OP_SUB:  ex_val = opa - opb;
            rvalu_pkg::OP_SLL:  ex_val = opa << sh;
            rvalu_pkg::OP_SLT:  ex_val = XLEN'($signed(opa) < $signed(opb));
            rvalu_pkg::OP_SLTU: ex_val = XLEN'(opa < opb);
            rvalu_pkg::OP_XOR:  ex_val = opa ^ opb;
            rvalu_pkg::OP_SRL:  ex_val = opa >> sh;
            rvalu_pkg::OP_SRA:  ex_val = $unsigned($signed(opa) >>> sh);
            rvalu_pkg::OP_OR:   ex_val = opa | opb;
            rvalu_pkg::OP_AND:  ex_val = opa & opb;
            default:            ex_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_reg_vld <= '0;
        end else begin
            if (pop) begin
                r_ex_vld <= 1'b1;
            end else if (ex_adv) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (ex_we) begin
                r_reg_vld[r_ex.rd] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ex      <= i_q_head;
            r_a_vld   <= r_reg_vld[i_q_head.rs1];
            r_b_vld   <= r_reg_vld[i_q_head.rs2];
            r_a_fwd   <= ex_we && (r_ex.rd == i_q_head.rs1);
            r_b_fwd   <= ex_we && (r_ex.rd == i_q_head.rs2);
            r_fwd_val <= ex_val;
        end
        if (ex_adv) begin
            r_out_op  <= r_ex.op;
            r_out_rd  <= r_ex.rd;
            r_out_val <= ex_val;
            r_out_wr  <= r_ex.wr;
        end
    end

    assign o_q_pop       = pop;
    assign o_out_valid   = r_out_vld;
    assign o_operation   = r_out_op;
    assign o_dest_index  = r_out_rd;
    assign o_write_value = $signed(r_out_val);
    assign o_did_write   = r_out_wr;

endmodule

@@ rtl/core/rv32i_register_alu_execute_unit.sv @@
// ----------------------------------------------------------------------------
// RV32I register-register ALU execute unit
// Path: queue, RF read register, then ALU into the result register.
// Throughput: one instruction per cycle unless stalled; dependent
// instructions issue back to back through the write-back bypass around the RF read register.
// Reset: synchronous; clears queue, pipeline valids and the per-register
// valid bits, so the register file reads as zero at once (no clear pass).
// ----------------------------------------------------------------------------
module rv32i_register_alu_execute_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_instruction,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_operation,
    output logic [4:0]         o_dest_index,
    output logic signed [31:0] o_write_value,
    output logic               o_did_write
);

    rvalu_pkg::t_uop dec_uop;
    rvalu_pkg::t_uop q_head;
    logic            q_empty, q_full, q_pop, push;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    rvalu_front u_front (
        .i_instruction (i_instruction),
        .o_uop         (dec_uop)
    );

    rvalu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (dec_uop),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rvalu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_operation   (o_operation),
        .o_dest_index  (o_dest_index),
        .o_write_value (o_write_value),
        .o_did_write   (o_did_write)
    );

`ifndef SYNTHESIS
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_write |-> o_dest_index != 5'd0)
        else $error("write to x0 reported");

    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_operation == 4'(rvalu_pkg::OP_BAD))
            |-> !o_did_write && (o_write_value == 32'sd0))
        else $error("unrecognized op wrote a value");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule
